>>> rtl/rip_pkg.sv
// Shared types, character codes and classification helpers for the
// regular-expression infix-to-prefix converter. No dependencies.
package rip_pkg;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;

    localparam logic [1:0] RANK_NONE = 2'd0;
    localparam logic [1:0] RANK_PLUS = 2'd1;
    localparam logic [1:0] RANK_DOT  = 2'd2;
    localparam logic [1:0] RANK_STAR = 2'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [2:0] {
        CLS_SYM,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP,
        CLS_IGN
    } t_cls;

    typedef struct packed {
        logic [7:0] ch;
        t_cls       cls;
    } t_sym;

    typedef struct packed {
        t_sym sym;
        logic last;
    } t_tok;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       out_empty;
        logic       out_overflow;
    } t_result;

    function automatic logic [1:0] rank_of(input logic [7:0] ch);
        logic [1:0] r;
        r = RANK_NONE;
        if (ch == CH_STAR) r = RANK_STAR;
        else if (ch == CH_DOT) r = RANK_DOT;
        else if (ch == CH_PLUS) r = RANK_PLUS;
        return r;
    endfunction

    // Mirrors the parentheses, then sorts the character into its class.
    function automatic t_sym classify(input logic [7:0] ch);
        t_sym s;
        s.ch = ch;
        if (ch == CH_LPAR) s.ch = CH_RPAR;
        else if (ch == CH_RPAR) s.ch = CH_LPAR;
        if ((s.ch >= 8'h61 && s.ch <= 8'h7A) || (s.ch >= 8'h41 && s.ch <= 8'h5A) ||
            (s.ch >= 8'h30 && s.ch <= 8'h39)) begin
            s.cls = CLS_SYM;
        end else if (s.ch == CH_LPAR) begin
            s.cls = CLS_OPEN;
        end else if (s.ch == CH_RPAR) begin
            s.cls = CLS_CLOSE;
        end else if (rank_of(s.ch) != RANK_NONE) begin
            s.cls = CLS_OP;
        end else begin
            s.cls = CLS_IGN;
        end
        return s;
    endfunction

endpackage

>>> rtl/rip_front.sv
// Input side of the converter: accepts characters and classifies them.
// Depends on rip_pkg.
module rip_front import rip_pkg::*; (
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_q_full,
    output logic  o_full,
    output logic  o_q_push,
    output t_tok  o_q_tok
);

    assign o_full      = i_q_full;
    assign o_q_push    = i_push && !i_q_full;
    assign o_q_tok.sym = classify(i_item.in_char);
    assign o_q_tok.last = i_item.in_last;

endmodule

>>> rtl/rip_queue.sv
// Short token queue between the front and back parts of the converter.
// Depends on rip_pkg.
module rip_queue import rip_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_tok,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_tok o_tok
);

    t_tok              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("token queue written while full");

endmodule

>>> rtl/rip_back.sv
// Back part of the converter: text store, operator stack, result store,
// conversion sequencer and the output register. Depends on rip_pkg.
module rip_back import rip_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_tok    i_q_tok,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_LEN);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHK,
        ST_RD,
        ST_EX,
        ST_PCLOSE,
        ST_PSTAR,
        ST_PLOW,
        ST_DRAIN,
        ST_NONE,
        ST_ERD,
        ST_EWR
    } t_state;

    // Sequencer registers.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CW-1:0]   r_i, n_i;
    logic [7:0]      r_cur, n_cur;
    logic [CW-1:0]   r_sp, n_sp;
    logic [7:0]      r_top, n_top;
    logic [CW-1:0]   r_rcount, n_rcount;
    logic [AW-1:0]   r_k, n_k;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;

    // Stores.
    t_sym            r_text [MAX_LEN];
    t_sym            r_tdata;
    logic [7:0]      r_stack [MAX_LEN];
    logic [7:0]      r_below;
    logic [7:0]      r_res [MAX_LEN];
    logic [7:0]      r_rdata;

    logic            txt_we;
    logic            push_en, push_ok, pop_en, sp_clear;
    logic [7:0]      push_data;
    logic            emit_req, res_we;
    logic [7:0]      emit_ch;
    logic            stk_we;
    logic [CW-1:0]   stk_wa_full, stk_ra_full, rc_m1;
    logic            slot_free;
    logic            finish;
    logic [1:0]      top_rank, cur_rank, held_rank;

    assign top_rank  = rank_of(r_top);
    assign cur_rank  = rank_of(r_tdata.ch);
    assign held_rank = rank_of(r_cur);
    assign slot_free = !r_out_valid || i_pop;
    assign rc_m1     = r_rcount - CW'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_i       = r_i;
        n_cur     = r_cur;
        n_k       = r_k;
        n_out     = r_out;
        o_q_pop   = 1'b0;
        txt_we    = 1'b0;
        push_en   = 1'b0;
        push_data = r_cur;
        pop_en    = 1'b0;
        sp_clear  = 1'b0;
        emit_req  = 1'b0;
        emit_ch   = r_top;
        finish    = 1'b0;
        n_out_valid = (i_pop) ? 1'b0 : r_out_valid;

        case (r_state)
            ST_LOAD: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (r_count < LIMIT) begin
                        txt_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_q_tok.last) begin
                        n_i      = n_count;
                        sp_clear = 1'b1;
                        n_state  = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                if (r_i == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_i     = r_i - CW'(1);
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_EX;
            end
            ST_EX: begin
                n_cur   = r_tdata.ch;
                n_state = ST_CHK;
                case (r_tdata.cls)
                    CLS_SYM: begin
                        emit_req = 1'b1;
                        emit_ch  = r_tdata.ch;
                    end
                    CLS_OPEN: begin
                        push_en   = 1'b1;
                        push_data = r_tdata.ch;
                    end
                    CLS_CLOSE: begin
                        n_state = ST_PCLOSE;
                    end
                    CLS_OP: begin
                        if (r_sp == '0 || cur_rank > top_rank) begin
                            push_en   = 1'b1;
                            push_data = r_tdata.ch;
                        end else if (cur_rank == top_rank && r_tdata.ch == CH_STAR) begin
                            n_state = ST_PSTAR;
                        end else if (cur_rank == top_rank) begin
                            push_en   = 1'b1;
                            push_data = r_tdata.ch;
                        end else begin
                            n_state = ST_PLOW;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_PCLOSE: begin
                if (r_sp != '0 && r_top != CH_LPAR) begin
                    pop_en   = 1'b1;
                    emit_req = 1'b1;
                end else begin
                    if (r_sp != '0) pop_en = 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_PSTAR: begin
                if (r_sp != '0 && top_rank == RANK_STAR) begin
                    pop_en   = 1'b1;
                    emit_req = 1'b1;
                end else begin
                    push_en = 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_PLOW: begin
                if (r_sp != '0 && held_rank < top_rank) begin
                    pop_en   = 1'b1;
                    emit_req = 1'b1;
                end else begin
                    push_en = 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_DRAIN: begin
                if (r_sp != '0) begin
                    pop_en   = 1'b1;
                    emit_req = 1'b1;
                end else if (r_rcount == '0) begin
                    n_state = ST_NONE;
                end else begin
                    n_k     = rc_m1[AW-1:0];
                    n_state = ST_ERD;
                end
            end
            ST_NONE: begin
                if (slot_free) begin
                    n_out_valid        = 1'b1;
                    n_out.out_char     = 8'h00;
                    n_out.out_last     = 1'b1;
                    n_out.out_empty    = 1'b1;
                    n_out.out_overflow = r_ovf;
                    finish             = 1'b1;
                end
            end
            ST_ERD: begin
                n_state = ST_EWR;
            end
            ST_EWR: begin
                if (slot_free) begin
                    n_out_valid        = 1'b1;
                    n_out.out_char     = r_rdata;
                    n_out.out_last     = (r_k == '0);
                    n_out.out_empty    = 1'b0;
                    n_out.out_overflow = r_ovf;
                    if (r_k == '0) begin
                        finish = 1'b1;
                    end else begin
                        n_k     = r_k - AW'(1);
                        n_state = ST_ERD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        if (finish) begin
            n_state = ST_LOAD;
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    // Stack and result-store bookkeeping.
    assign push_ok  = push_en && (r_sp < LIMIT);
    assign res_we   = emit_req && emit_ch != CH_LPAR && emit_ch != CH_RPAR &&
                      (r_rcount < LIMIT);
    assign n_rcount = sp_clear ? '0 : r_rcount + CW'(res_we);
    assign n_sp     = sp_clear ? '0 : r_sp + CW'(push_ok) - CW'(pop_en);
    assign n_top    = push_ok ? push_data : (pop_en ? r_below : r_top);
    assign stk_we      = push_ok && (r_sp != '0);
    assign stk_wa_full = r_sp - CW'(1);
    assign stk_ra_full = n_sp - CW'(2);

    always_ff @(posedge i_clk) begin
        if (txt_we) begin
            r_text[r_count[AW-1:0]] <= i_q_tok.sym;
        end
        r_tdata <= r_text[r_i[AW-1:0]];
    end

    // The entry below the top is prefetched; a push writes the old top
    // into exactly the slot being prefetched, so it is forwarded.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_wa_full[AW-1:0]] <= r_top;
        end
        r_below <= stk_we ? r_top : r_stack[stk_ra_full[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_res[r_rcount[AW-1:0]] <= emit_ch;
        end
        r_rdata <= r_res[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_sp        <= '0;
            r_rcount    <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_i         <= n_i;
            r_sp        <= n_sp;
            r_rcount    <= n_rcount;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_cur <= n_cur;
        r_top <= n_top;
        r_out <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_sp <= LIMIT)
        else $error("operator stack pointer beyond its depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LIMIT && r_rcount <= LIMIT)
        else $error("text or result count beyond its depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) pop_en |-> r_sp != '0)
        else $error("operator stack popped while empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.out_empty) |-> r_out.out_last)
        else $error("empty-prefix transaction without last flag");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |=> (r_count == $past(r_count) || r_count == '0))
        else $error("text count changed during conversion");

endmodule

>>> rtl/regex_infix_to_prefix.sv
// Top level of the regular-expression infix-to-prefix converter.
// Depends on rip_pkg, rip_front, rip_queue and rip_back.
//
//   Channel   Handshake          Payload    Transaction moves
//   --------  -----------------  ---------  ------------------------------------
//   input     push / full        i_item     one infix character plus last flag
//   result    empty / pop        o_result   one prefix character with flags
//
// Characters are taken one per cycle while the four-entry token queue has room.
// Once the last character arrives, the back part scans the stored text
// backwards through a check, a read and an execute state per character;
// closing marks and operators that must pop the stack first pass through a
// popping state, and the scan ends by draining the stack, one entry per cycle.
// Results then leave one at a time via the registered result-store read.
// Reset is synchronous and active low and needs no clearing pass.
// Either side may stall freely: the output register holds a result until it is
// popped, and the queue takes up to four characters while conversion runs.
module regex_infix_to_prefix import rip_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic q_full;
    logic q_push;
    t_tok q_in_tok;
    logic q_valid;
    t_tok q_out_tok;
    logic q_pop;

    // The front part classifies each character and mirrors parentheses so
    // that the back part only has to scan the text backwards.
    rip_front u_front (
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_tok  (q_in_tok)
    );

    rip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (q_in_tok),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tok   (q_out_tok)
    );

    // The back part stores the text, runs the precedence stack, and emits
    // the reversed output through its result register.
    rip_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_tok   (q_out_tok),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule
